>>> hw/rtl/pip_pkg.sv
// Shared types and constants for the point-in-polygon test core.
`default_nettype none

package pip_pkg;

  // Input opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam int unsigned CoordW = 16;
  localparam int unsigned CountW = 5;
  localparam int unsigned IndexW = 4;

  typedef logic signed [CoordW-1:0] coord_t;

  // One stored polygon vertex
  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  // Status of the edge pipeline as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic tog_valid;
    logic tog;
  } edge_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/pip_edge_unit.sv
// Three-stage edge crossing pipeline: differences, products, compare.
`default_nettype none

module pip_edge_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              edge_valid_i,
  input  pip_pkg::vertex_t  vi_i,
  input  pip_pkg::vertex_t  vj_i,
  input  pip_pkg::coord_t   px_i,
  input  pip_pkg::coord_t   py_i,
  output pip_pkg::edge_stat_t stat_o
);
  import pip_pkg::*;

  // The crossing test px <= trunc(num/den) + xi is done without a divider.
  // With den made positive (num negated to match) and d = px - xi:
  //   num >= 0: floor(num/den) >= d  <=>  num >= d*den
  //   num <  0: ceil(num/den)  >= d  <=>  num >  d*den - den

  // Stage A: differences
  logic               a_valid_q;
  logic               a_cross_q;
  logic signed [16:0] a_dx_q;
  logic signed [17:0] a_dy_q;
  logic signed [16:0] a_den_q;
  logic signed [16:0] a_dpx_q;

  logic signed [16:0] dx_d, dyp_d, den_d, dpx_d;
  logic signed [17:0] dy_d;
  logic signed [16:0] dena_d;
  logic               cross_d;

  always_comb begin
    dx_d    = $signed({vj_i.x[15], vj_i.x}) - $signed({vi_i.x[15], vi_i.x});
    dyp_d   = $signed({py_i[15], py_i}) - $signed({vi_i.y[15], vi_i.y});
    den_d   = $signed({vj_i.y[15], vj_i.y}) - $signed({vi_i.y[15], vi_i.y});
    dpx_d   = $signed({px_i[15], px_i}) - $signed({vi_i.x[15], vi_i.x});
    cross_d = (vi_i.y >= py_i) != (vj_i.y >= py_i);
    // Make the divisor positive
    if (den_d[16]) begin
      dy_d   = -$signed({dyp_d[16], dyp_d});
      dena_d = -den_d;
    end else begin
      dy_d   = $signed({dyp_d[16], dyp_d});
      dena_d = den_d;
    end
  end

  // Stage B: products
  logic               b_valid_q;
  logic               b_cross_q;
  logic signed [34:0] b_num_q;
  logic signed [33:0] b_prod_q;
  logic signed [16:0] b_den_q;

  // Stage C: compare result
  logic               c_valid_q;
  logic               c_tog_q;

  logic signed [35:0] num_w, prod_w, prod_lo_w;
  logic               hit_w;

  always_comb begin
    num_w     = 36'(b_num_q);
    prod_w    = 36'(b_prod_q);
    prod_lo_w = prod_w - 36'(b_den_q);
    hit_w     = b_num_q[34] ? (num_w > prod_lo_w) : (num_w >= prod_w);
  end

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= edge_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // Advance data
  always_ff @(posedge clk_i) begin
    if (edge_valid_i) begin
      a_cross_q <= cross_d;
      a_dx_q    <= dx_d;
      a_dy_q    <= dy_d;
      a_den_q   <= dena_d;
      a_dpx_q   <= dpx_d;
    end
    if (a_valid_q) begin
      b_cross_q <= a_cross_q;
      b_num_q   <= 35'(a_dx_q * a_dy_q);
      b_prod_q  <= 34'(a_dpx_q * a_den_q);
      b_den_q   <= a_den_q;
    end
    if (b_valid_q) begin
      c_tog_q <= b_cross_q & hit_w;
    end
  end

  assign stat_o.busy      = a_valid_q | b_valid_q | c_valid_q;
  assign stat_o.tog_valid = c_valid_q;
  assign stat_o.tog       = c_tog_q;

endmodule

`default_nettype wire

>>> hw/rtl/point_in_polygon_test_core.sv
// Top level of the ray-casting point-in-polygon test core.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, opcode_i, vertex_index_i, | sink
//           | item_x_i, item_y_i                             |
//   out     | out_valid_o/out_ready_i, inside_res_o          | source
//   cfg     | cfg_we_i, cfg_wdata_i (vertex_count)            | write only
//
// A load transfer writes the vertex memory at once. A test transfer makes n + 1 memory
// reads, n being vertex_count saturated to MAX_VERTICES, then drains the three-stage
// edge pipeline and finishes. With n zero the test goes straight to the finish step.
// One item is in work at a time; the result register lets a new item in while the
// last answer waits, and a full result register holds the finish step. Reset clears
// vertex_count and control; the vertex memory is not cleared.
`default_nettype none

module point_in_polygon_test_core #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic [pip_pkg::IndexW-1:0]  vertex_index_i,
  input  pip_pkg::coord_t             item_x_i,
  input  pip_pkg::coord_t             item_y_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        inside_res_o,
  input  logic                        cfg_we_i,
  input  logic [pip_pkg::CountW-1:0]  cfg_wdata_i
);
  import pip_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_VERTICES);
  localparam int unsigned CntW  = $clog2(MAX_VERTICES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e            state_q;
  logic [CountW-1:0] vertex_count_q;
  logic [CntW-1:0]   n_q;
  logic [CntW-1:0]   k_q;
  logic              parity_q;
  logic              out_valid_q;
  logic              inside_q;
  logic              s0_valid_q;
  logic              s0_edge_q;
  coord_t            px_q, py_q;
  vertex_t           rd_data_q;
  vertex_t           prev_q;
  vertex_t           mem [MAX_VERTICES];

  logic              in_xfer;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic              query_start;
  logic [CntW-1:0]   n_sat;
  logic [CntW-1:0]   n_m1, k_m1;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  edge_stat_t        edge_stat;

  // Accept and decode input transfers
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign wr_en       = in_xfer && (opcode_i == OP_LOAD) &&
                       (int'(vertex_index_i) < MAX_VERTICES);
  assign wr_addr     = AddrW'(vertex_index_i);
  assign query_start = in_xfer && (opcode_i == OP_TEST);

  // Saturate the vertex count to the memory depth
  assign n_sat = (int'(vertex_count_q) > MAX_VERTICES) ?
                 CntW'(MAX_VERTICES) : CntW'(vertex_count_q);

  // Read the closing vertex first, then vertices 0 .. n-1
  assign n_m1    = n_q - 1'b1;
  assign k_m1    = k_q - 1'b1;
  assign rd_en   = (state_q == ST_WALK);
  assign rd_addr = (k_q == '0) ? n_m1[AddrW-1:0] : k_m1[AddrW-1:0];

  // Vertex memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= '{x: item_x_i, y: item_y_i};
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Hold the query point and the previous vertex
  always_ff @(posedge clk_i) begin
    if (query_start) begin
      px_q <= item_x_i;
      py_q <= item_y_i;
    end
    if (s0_valid_q) begin
      prev_q <= rd_data_q;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= '0;
    end else if (cfg_we_i) begin
      vertex_count_q <= cfg_wdata_i;
    end
  end

  pip_edge_unit u_edge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .edge_valid_i (s0_edge_q),
    .vi_i         (rd_data_q),
    .vj_i         (prev_q),
    .px_i         (px_q),
    .py_i         (py_q),
    .stat_o       (edge_stat)
  );

  // Sequencer, parity and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      k_q         <= '0;
      parity_q    <= 1'b0;
      s0_valid_q  <= 1'b0;
      s0_edge_q   <= 1'b0;
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
    end else begin
      s0_valid_q <= rd_en;
      s0_edge_q  <= rd_en && (k_q != '0);

      if (edge_stat.tog_valid && edge_stat.tog) begin
        parity_q <= ~parity_q;
      end

      // Drop the result once the output transfer completes
      if (out_valid_q && out_ready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (query_start) begin
            n_q      <= n_sat;
            k_q      <= '0;
            parity_q <= 1'b0;
            state_q  <= (n_sat == '0) ? ST_FINISH : ST_WALK;
          end
        end
        ST_WALK: begin
          k_q <= k_q + 1'b1;
          if (k_q == n_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s0_valid_q && !edge_stat.busy) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            inside_q    <= parity_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

endmodule

`default_nettype wire
